>>> rtl/lgs_pkg.sv
// Shared types and constants of the collapsed Gibbs token sampler.
// No dependencies; every RTL file of the sampler imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

    localparam int MAX_TOPICS = 64;
    localparam int MAX_VOCAB  = 4096;
    localparam int MAX_DOCS   = 256;
    localparam int MAX_TOKENS = 65536;
    localparam int NUM_GROUPS = 4;

    localparam int TOPIC_W = $clog2(MAX_TOPICS);
    localparam int KCNT_W  = TOPIC_W + 1;
    localparam int WORD_W  = $clog2(MAX_VOCAB);
    localparam int VOCAB_W = WORD_W + 1;
    localparam int DOC_W   = $clog2(MAX_DOCS);
    localparam int SLOT_W  = $clog2(MAX_TOKENS);
    localparam int GROUP_W = $clog2(NUM_GROUPS);
    localparam int CNT_W   = 16;
    localparam int RND_W   = 32;
    localparam int PRIOR_W = 32;
    localparam int FRAC_W  = 16;

    localparam int WCOUNT_W = 24;
    localparam int GSUM_W   = 32;
    localparam int DSUM_W   = 24;

    localparam int A_W      = WCOUNT_W + FRAC_W + 1;
    localparam int VETA_W   = VOCAB_W + PRIOR_W;
    localparam int D_W      = GSUM_W + FRAC_W + 1;
    localparam int PROD_W   = 2 * A_W;
    localparam int WEIGHT_W = 48;
    localparam int SUM_W    = WEIGHT_W + TOPIC_W;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_LOAD_WORD  = 2'd0,
        CMD_LOAD_GROUP = 2'd1,
        CMD_SAMPLE     = 2'd2,
        CMD_READ_WORD  = 2'd3
    } cmd_t;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_WORD_RANGE = 3'd1;
    localparam logic [2:0] STAT_UNDERFLOW = 3'd2;
    localparam logic [2:0] STAT_UNIFORM   = 3'd3;
    localparam logic [2:0] STAT_PASSED    = 3'd4;

    localparam logic [2:0] CFG_NUM_TOPICS = 3'd0;
    localparam logic [2:0] CFG_VOCAB_SIZE = 3'd1;
    localparam logic [2:0] CFG_ALPHA      = 3'd2;
    localparam logic [2:0] CFG_ETA        = 3'd3;
    localparam logic [2:0] CFG_FIRST_DOC  = 3'd4;

    typedef struct packed {
        logic                rd;
        logic                wr_w;
        logic                wr_g;
        logic                wr_d;
        logic [WORD_W-1:0]   word;
        logic [GROUP_W-1:0]  grp;
        logic [DOC_W-1:0]    doc;
        logic [TOPIC_W-1:0]  topic;
        logic [WCOUNT_W-1:0] w;
        logic [GSUM_W-1:0]   g;
        logic [DSUM_W-1:0]   d;
    } cs_req_t;

    typedef struct packed {
        logic [WCOUNT_W-1:0] w;
        logic [GSUM_W-1:0]   g;
        logic [DSUM_W-1:0]   d;
    } cs_data_t;

    typedef struct packed {
        logic               rd;
        logic               wr;
        logic [SLOT_W-1:0]  slot;
        logic [TOPIC_W-1:0] topic;
    } slot_req_t;

    typedef struct packed {
        logic               valid;
        logic [TOPIC_W-1:0] topic;
    } slot_data_t;

    typedef struct packed {
        logic           start;
        logic [A_W-1:0] a;
        logic [A_W-1:0] b;
        logic [D_W-1:0] d;
    } wu_req_t;

endpackage

`default_nettype wire

>>> rtl/lgs_count_store.sv
// Word-topic, group-topic and document-topic count memories.
// Depends on lgs_pkg. Document counts are zeroed by a sweep after reset.
`timescale 1ns / 1ps
`default_nettype none

module lgs_count_store (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lgs_pkg::cs_req_t req,
    output lgs_pkg::cs_data_t     rdata,
    output logic                  clearing
);
    import lgs_pkg::*;

    localparam int WADDR_W = WORD_W + TOPIC_W;
    localparam int GADDR_W = GROUP_W + TOPIC_W;
    localparam int DADDR_W = DOC_W + TOPIC_W;

    logic [WCOUNT_W-1:0] wmem [2**WADDR_W];
    logic [GSUM_W-1:0]   gmem [2**GADDR_W];
    logic [DSUM_W-1:0]   dmem [2**DADDR_W];

    logic [DADDR_W:0] clr_reg;
    logic [WADDR_W-1:0] waddr;
    logic [GADDR_W-1:0] gaddr;
    logic [DADDR_W-1:0] daddr;

    assign waddr    = {req.word, req.topic};
    assign gaddr    = {req.grp, req.topic};
    assign daddr    = {req.doc, req.topic};
    assign clearing = !clr_reg[DADDR_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_w)
        begin
            wmem[waddr] <= req.w;
        end
        if (req.rd)
        begin
            rdata.w <= wmem[waddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_g)
        begin
            gmem[gaddr] <= req.g;
        end
        if (req.rd)
        begin
            rdata.g <= gmem[gaddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            dmem[clr_reg[DADDR_W-1:0]] <= '0;
        end
        else if (req.wr_d)
        begin
            dmem[daddr] <= req.d;
        end
        if (req.rd)
        begin
            rdata.d <= dmem[daddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/lgs_slot_store.sv
// Token assignment memory: a valid flag and a topic per token slot.
// Depends on lgs_pkg. Cleared to unassigned by a sweep after reset.
`timescale 1ns / 1ps
`default_nettype none

module lgs_slot_store (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lgs_pkg::slot_req_t req,
    output lgs_pkg::slot_data_t     rdata,
    output logic                    clearing
);
    import lgs_pkg::*;

    slot_data_t smem [MAX_TOKENS];
    logic [SLOT_W:0] clr_reg;

    assign clearing = !clr_reg[SLOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            smem[clr_reg[SLOT_W-1:0]] <= '0;
        end
        else if (req.wr)
        begin
            smem[req.slot] <= '{valid: 1'b1, topic: req.topic};
        end
        if (req.rd)
        begin
            rdata <= smem[req.slot];
        end
    end

endmodule

`default_nettype wire

>>> rtl/lgs_weight_unit.sv
// Topic weight unit: floor(A*B/D) in Q16, saturated to the weight width.
// Depends on lgs_pkg. Four partial products, then one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module lgs_weight_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lgs_pkg::wu_req_t req,
    output logic                  done,
    output logic [lgs_pkg::WEIGHT_W-1:0] weight
);
    import lgs_pkg::*;

    localparam int HALF_W = (A_W + 1) / 2;
    localparam int HI_W   = PROD_W - WEIGHT_W;
    localparam int STEP_W = $clog2(WEIGHT_W);

    typedef enum logic [2:0] {
        W_IDLE,
        W_MUL,
        W_CHK,
        W_DIV,
        W_DONE
    } wstate_t;

    wstate_t             state_reg;
    logic [A_W-1:0]      a_reg;
    logic [A_W-1:0]      b_reg;
    logic [D_W-1:0]      d_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic [1:0]          step_reg;
    logic [D_W-1:0]      rem_reg;
    logic [WEIGHT_W-1:0] low_reg;
    logic [STEP_W-1:0]   bit_reg;
    logic [WEIGHT_W-1:0] q_reg;

    logic [HALF_W-1:0]   pa;
    logic [HALF_W-1:0]   pb;
    logic [2*HALF_W-1:0] pp;
    logic [PROD_W-1:0]   pp_shifted;
    logic [D_W:0]        trial;
    logic                ge;
    logic [HI_W-1:0]     prod_hi;

    always_comb
    begin
        pa = step_reg[1] ? HALF_W'(a_reg[A_W-1:HALF_W]) : a_reg[HALF_W-1:0];
        pb = step_reg[0] ? HALF_W'(b_reg[A_W-1:HALF_W]) : b_reg[HALF_W-1:0];
        pp = pa * pb;
        case (step_reg)
            2'd0:    pp_shifted = PROD_W'(pp);
            2'd3:    pp_shifted = PROD_W'(pp) << (2 * HALF_W);
            default: pp_shifted = PROD_W'(pp) << HALF_W;
        endcase
        trial   = {rem_reg, low_reg[WEIGHT_W-1]};
        ge      = trial >= {1'b0, d_reg};
        prod_hi = acc_reg[PROD_W-1:WEIGHT_W];
    end

    assign done   = (state_reg == W_DONE);
    assign weight = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            step_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                W_IDLE:
                begin
                    if (req.start)
                    begin
                        a_reg     <= req.a;
                        b_reg     <= req.b;
                        d_reg     <= req.d;
                        acc_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= W_MUL;
                    end
                end
                W_MUL:
                begin
                    acc_reg  <= acc_reg + pp_shifted;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 2'd3)
                    begin
                        state_reg <= W_CHK;
                    end
                end
                W_CHK:
                begin
                    if (d_reg == '0)
                    begin
                        q_reg     <= (acc_reg != '0) ? WEIGHT_MAX : '0;
                        state_reg <= W_DONE;
                    end
                    else if (D_W'(prod_hi) >= d_reg)
                    begin
                        // quotient would not fit: saturate
                        q_reg     <= WEIGHT_MAX;
                        state_reg <= W_DONE;
                    end
                    else
                    begin
                        rem_reg   <= D_W'(prod_hi);
                        low_reg   <= acc_reg[WEIGHT_W-1:0];
                        q_reg     <= '0;
                        bit_reg   <= '0;
                        state_reg <= W_DIV;
                    end
                end
                W_DIV:
                begin
                    rem_reg <= ge ? D_W'(trial - {1'b0, d_reg}) : trial[D_W-1:0];
                    low_reg <= {low_reg[WEIGHT_W-2:0], 1'b0};
                    q_reg   <= {q_reg[WEIGHT_W-2:0], ge};
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == STEP_W'(WEIGHT_W - 1))
                    begin
                        state_reg <= W_DONE;
                    end
                end
                W_DONE:
                begin
                    state_reg <= W_IDLE;
                end
                default:
                begin
                    state_reg <= W_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/lda_collapsed_gibbs_token_sampler_unit.sv
// Top level of the collapsed Gibbs token sampler: sequencer, weight buffer,
// configuration registers and result register. Depends on lgs_pkg and the
// count store, slot store and weight unit.
`timescale 1ns / 1ps
`default_nettype none

// Collapsed Gibbs sampler for one LDA token per beat. Commands load word
// counts or group sums, read a word count, or sample a token. After reset a
// clearing pass empties the token assignments and zeroes the document
// counts; sample_stall stays high during it, configuration writes are taken
// at any time (cfg_ready is tied high). One item is worked on at a time: a
// new beat is not accepted until the sequencer is back in idle. A resample
// of a token computes each topic's weight in turn on the shared weight unit
// (four partial products, a range check, one quotient bit per cycle over 48
// bits, and a done step; a saturating or zero-divisor weight ends early),
// then the selection scan reads the weight buffer one topic at a time, a
// read step then a check step (skipped on a zero weight sum). The next
// beat is accepted while a finished result still waits in the output
// register; a finished item waits in its last step while that register is
// full and stalled.
module lda_collapsed_gibbs_token_sampler_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire logic [1:0]                    command,
    input  wire logic [lgs_pkg::DOC_W-1:0]     document,
    input  wire logic [lgs_pkg::SLOT_W-1:0]    token_slot,
    input  wire logic [lgs_pkg::WORD_W-1:0]    word,
    input  wire logic [lgs_pkg::GROUP_W-1:0]   vocab_group,
    input  wire logic [lgs_pkg::CNT_W-1:0]     count,
    input  wire logic [lgs_pkg::TOPIC_W-1:0]   initial_topic,
    input  wire logic                          has_initial,
    input  wire logic [lgs_pkg::WCOUNT_W-1:0]  load_value,
    input  wire logic [lgs_pkg::RND_W-1:0]     random_fraction,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [lgs_pkg::TOPIC_W-1:0]        assigned_topic,
    output logic [lgs_pkg::WCOUNT_W-1:0]       read_value,
    output logic [2:0]                         status,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [31:0]                   cfg_data
);
    import lgs_pkg::*;

    localparam int UNI_W = RND_W + KCNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ_WAIT,
        S_EARLY_WAIT,
        S_SLOT_WAIT,
        S_OLD_WAIT,
        S_W_RD,
        S_W_LOAD,
        S_W_WAIT,
        S_T0,
        S_T1,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ADD_RD,
        S_ADD_WAIT,
        S_FINISH
    } state_t;

    // configuration
    logic [KCNT_W-1:0]  num_topics_reg;
    logic [VOCAB_W-1:0] vocab_size_reg;
    logic [PRIOR_W-1:0] alpha_reg;
    logic [PRIOR_W-1:0] eta_reg;
    logic [DOC_W:0]     first_doc_reg;

    // latched beat
    cmd_t                cmd_reg;
    logic [DOC_W-1:0]    doc_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [WORD_W-1:0]   word_reg;
    logic [GROUP_W-1:0]  grp_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [TOPIC_W-1:0]  itop_reg;
    logic                init_reg;
    logic [WCOUNT_W-1:0] lval_reg;
    logic [RND_W-1:0]    rnd_reg;
    logic [VETA_W-1:0]   veta_reg;

    // working state
    state_t              state_reg;
    logic [TOPIC_W-1:0]  k_reg;
    logic [TOPIC_W-1:0]  topic_reg;
    logic [2:0]          status_reg;
    logic [WCOUNT_W-1:0] rval_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    prefix_reg;
    logic [SUM_W+RND_W-1:0] prod_reg;

    // result register
    logic                res_valid_reg;
    logic [TOPIC_W-1:0]  res_topic_reg;
    logic [WCOUNT_W-1:0] res_rval_reg;
    logic [2:0]          res_status_reg;

    // weight buffer
    logic [WEIGHT_W-1:0] wb_mem [MAX_TOPICS];
    logic [WEIGHT_W-1:0] wb_q_reg;

    cs_req_t    cs_req;
    cs_data_t   cs_data;
    slot_req_t  sl_req;
    slot_data_t sl_data;
    wu_req_t    wu_req;
    logic       wu_done;
    logic [WEIGHT_W-1:0] wu_weight;
    logic       cs_clearing;
    logic       sl_clearing;

    logic [KCNT_W-1:0]  k_use;
    logic [KCNT_W-1:0]  k_last;
    logic [VOCAB_W-1:0] v_use;
    logic [UNI_W-1:0]   uni_prod;
    logic [TOPIC_W-1:0] uni_topic;
    logic [SUM_W-1:0]   target;
    logic [SUM_W-1:0]   prefix_next;
    logic               underflow;
    logic [WCOUNT_W:0]  w_add;
    logic [GSUM_W:0]    g_add;
    logic [DSUM_W:0]    d_add;
    logic               accept;

    lgs_count_store u_counts (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (cs_req),
        .rdata    (cs_data),
        .clearing (cs_clearing)
    );

    lgs_slot_store u_slots (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (sl_req),
        .rdata    (sl_data),
        .clearing (sl_clearing)
    );

    lgs_weight_unit u_weight (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (wu_req),
        .done   (wu_done),
        .weight (wu_weight)
    );

    assign cfg_ready    = 1'b1;
    assign sample_stall = (state_reg != S_IDLE) || cs_clearing || sl_clearing;
    assign accept       = sample_valid && !sample_stall;

    assign result_valid   = res_valid_reg;
    assign assigned_topic = res_topic_reg;
    assign read_value     = res_rval_reg;
    assign status         = res_status_reg;

    // effective K and V
    always_comb
    begin
        if (num_topics_reg == '0)
        begin
            k_use = KCNT_W'(1);
        end
        else if (num_topics_reg > KCNT_W'(MAX_TOPICS))
        begin
            k_use = KCNT_W'(MAX_TOPICS);
        end
        else
        begin
            k_use = num_topics_reg;
        end
        k_last = k_use - 1'b1;
        v_use  = (vocab_size_reg > VOCAB_W'(MAX_VOCAB)) ? VOCAB_W'(MAX_VOCAB)
                                                         : vocab_size_reg;
        uni_prod    = rnd_reg * k_use;
        uni_topic   = uni_prod[RND_W+TOPIC_W-1:RND_W];
        target      = prod_reg[SUM_W+RND_W-1:RND_W];
        prefix_next = prefix_reg + SUM_W'(wb_q_reg);
        underflow   = (cs_data.w < WCOUNT_W'(cnt_reg)) ||
                      (cs_data.g < GSUM_W'(cnt_reg)) ||
                      (cs_data.d < DSUM_W'(cnt_reg));
        w_add = {1'b0, cs_data.w} + (WCOUNT_W + 1)'(cnt_reg);
        g_add = {1'b0, cs_data.g} + (GSUM_W + 1)'(cnt_reg);
        d_add = {1'b0, cs_data.d} + (DSUM_W + 1)'(cnt_reg);
    end

    // memory and weight unit requests, decoded from the state
    always_comb
    begin
        cs_req       = '0;
        cs_req.word  = word_reg;
        cs_req.grp   = grp_reg;
        cs_req.doc   = doc_reg;
        cs_req.topic = topic_reg;
        sl_req       = '0;
        sl_req.slot  = slot_reg;
        sl_req.topic = topic_reg;
        wu_req.start = 1'b0;
        wu_req.a     = (A_W'(cs_data.d) << FRAC_W) + A_W'(alpha_reg);
        wu_req.b     = (A_W'(cs_data.w) << FRAC_W) + A_W'(eta_reg);
        wu_req.d     = (D_W'(cs_data.g) << FRAC_W) + D_W'(veta_reg);
        case (state_reg)
            S_DISPATCH:
            begin
                cs_req.topic = itop_reg;
                cs_req.w     = lval_reg;
                cs_req.g     = GSUM_W'(lval_reg);
                case (cmd_reg)
                    CMD_LOAD_WORD:  cs_req.wr_w = 1'b1;
                    CMD_LOAD_GROUP: cs_req.wr_g = 1'b1;
                    CMD_READ_WORD:  cs_req.rd   = 1'b1;
                    default:        sl_req.rd   = 1'b1;
                endcase
            end
            S_SLOT_WAIT:
            begin
                cs_req.topic = sl_data.topic;
                cs_req.rd    = sl_data.valid;
            end
            S_OLD_WAIT:
            begin
                cs_req.w    = cs_data.w - WCOUNT_W'(cnt_reg);
                cs_req.g    = cs_data.g - GSUM_W'(cnt_reg);
                cs_req.d    = cs_data.d - DSUM_W'(cnt_reg);
                cs_req.wr_w = !underflow;
                cs_req.wr_g = !underflow;
                cs_req.wr_d = !underflow;
            end
            S_W_RD:
            begin
                cs_req.topic = k_reg;
                cs_req.rd    = 1'b1;
            end
            S_W_LOAD:
            begin
                wu_req.start = 1'b1;
            end
            S_ADD_RD:
            begin
                cs_req.rd = 1'b1;
            end
            S_ADD_WAIT:
            begin
                // saturating adds at the store widths
                cs_req.w    = w_add[WCOUNT_W] ? {WCOUNT_W{1'b1}} : w_add[WCOUNT_W-1:0];
                cs_req.g    = g_add[GSUM_W] ? {GSUM_W{1'b1}} : g_add[GSUM_W-1:0];
                cs_req.d    = d_add[DSUM_W] ? {DSUM_W{1'b1}} : d_add[DSUM_W-1:0];
                cs_req.wr_w = 1'b1;
                cs_req.wr_g = 1'b1;
                cs_req.wr_d = 1'b1;
                sl_req.wr   = 1'b1;
            end
            default:
            begin
                cs_req.rd = 1'b0;
            end
        endcase
    end

    // weight buffer
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_W_WAIT) && wu_done)
        begin
            wb_mem[k_reg] <= wu_weight;
        end
        if (state_reg == S_SCAN_RD)
        begin
            wb_q_reg <= wb_mem[k_reg];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_topics_reg <= KCNT_W'(32);
            vocab_size_reg <= VOCAB_W'(4096);
            alpha_reg      <= PRIOR_W'(6554);
            eta_reg        <= PRIOR_W'(6554);
            first_doc_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NUM_TOPICS: num_topics_reg <= cfg_data[KCNT_W-1:0];
                CFG_VOCAB_SIZE: vocab_size_reg <= cfg_data[VOCAB_W-1:0];
                CFG_ALPHA:      alpha_reg      <= cfg_data;
                CFG_ETA:        eta_reg        <= cfg_data;
                CFG_FIRST_DOC:  first_doc_reg  <= cfg_data[DOC_W:0];
                default:        first_doc_reg  <= first_doc_reg;
            endcase
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            // the finish step refills the result register itself
            if (res_valid_reg && !result_stall && (state_reg != S_FINISH))
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg    <= cmd_t'(command);
                        doc_reg    <= document;
                        slot_reg   <= token_slot;
                        word_reg   <= word;
                        grp_reg    <= vocab_group;
                        cnt_reg    <= count;
                        itop_reg   <= initial_topic;
                        init_reg   <= has_initial;
                        lval_reg   <= load_value;
                        rnd_reg    <= random_fraction;
                        veta_reg   <= v_use * eta_reg;
                        topic_reg  <= '0;
                        status_reg <= STAT_OK;
                        rval_reg   <= '0;
                        state_reg  <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    case (cmd_reg)
                        CMD_READ_WORD:
                        begin
                            state_reg <= S_READ_WAIT;
                        end
                        CMD_SAMPLE:
                        begin
                            if ({1'b0, doc_reg} < first_doc_reg)
                            begin
                                state_reg <= S_EARLY_WAIT;
                            end
                            else if ({1'b0, word_reg} >= v_use)
                            begin
                                status_reg <= STAT_WORD_RANGE;
                                state_reg  <= S_FINISH;
                            end
                            else
                            begin
                                state_reg <= S_SLOT_WAIT;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_FINISH;
                        end
                    endcase
                end
                S_READ_WAIT:
                begin
                    rval_reg  <= cs_data.w;
                    state_reg <= S_FINISH;
                end
                S_EARLY_WAIT:
                begin
                    // document before the resampled range: report stored topic
                    status_reg <= STAT_PASSED;
                    topic_reg  <= sl_data.valid ? sl_data.topic : '0;
                    state_reg  <= S_FINISH;
                end
                S_SLOT_WAIT:
                begin
                    if (sl_data.valid)
                    begin
                        topic_reg <= sl_data.topic;
                        state_reg <= S_OLD_WAIT;
                    end
                    else if (init_reg && ({1'b0, itop_reg} < k_use))
                    begin
                        topic_reg <= itop_reg;
                        state_reg <= S_ADD_RD;
                    end
                    else
                    begin
                        // uniform pick; a preset beyond K counts as fallback
                        topic_reg  <= uni_topic;
                        status_reg <= init_reg ? STAT_UNIFORM : STAT_OK;
                        state_reg  <= S_ADD_RD;
                    end
                end
                S_OLD_WAIT:
                begin
                    if (underflow)
                    begin
                        status_reg <= STAT_UNDERFLOW;
                        state_reg  <= S_FINISH;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_W_RD;
                    end
                end
                S_W_RD:
                begin
                    state_reg <= S_W_LOAD;
                end
                S_W_LOAD:
                begin
                    state_reg <= S_W_WAIT;
                end
                S_W_WAIT:
                begin
                    if (wu_done)
                    begin
                        sum_reg <= sum_reg + SUM_W'(wu_weight);
                        if ({1'b0, k_reg} == k_last)
                        begin
                            state_reg <= S_T0;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_W_RD;
                        end
                    end
                end
                S_T0:
                begin
                    if (sum_reg == '0)
                    begin
                        topic_reg  <= uni_topic;
                        status_reg <= STAT_UNIFORM;
                        state_reg  <= S_ADD_RD;
                    end
                    else
                    begin
                        // target = r * sum / 2^32, low half of sum first
                        prod_reg  <= (SUM_W + RND_W)'(rnd_reg * sum_reg[SUM_W/2-1:0]);
                        state_reg <= S_T1;
                    end
                end
                S_T1:
                begin
                    prod_reg   <= prod_reg + ((SUM_W + RND_W)'(rnd_reg *
                                  sum_reg[SUM_W-1:SUM_W/2]) << (SUM_W / 2));
                    k_reg      <= '0;
                    prefix_reg <= '0;
                    state_reg  <= S_SCAN_RD;
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    prefix_reg <= prefix_next;
                    if ((target < prefix_next) || ({1'b0, k_reg} == k_last))
                    begin
                        topic_reg <= k_reg;
                        state_reg <= S_ADD_RD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_ADD_RD:
                begin
                    state_reg <= S_ADD_WAIT;
                end
                S_ADD_WAIT:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!res_valid_reg || !result_stall)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_topic_reg  <= topic_reg;
                        res_rval_reg   <= rval_reg;
                        res_status_reg <= status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_FINISH))
        else $error("result beat raised outside the finish step");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_DISPATCH)
        else $error("beat accepted while an item was in work");

    a_topic_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADD_RD |-> {1'b0, topic_reg} < k_use)
        else $error("chosen topic beyond topics in use");

    a_weight_started_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_W_LOAD |=> !wu_done)
        else $error("weight unit finished in the cycle after its start");

endmodule

`default_nettype wire
